// ===== rtl/asps_pkg.sv =====
// ----------------------------------------------------------------------------
// asps_pkg: shared types and constants for the additive sine partial synth
// Mode codes, sequencer states, sample limits and the sine ROM generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asps_pkg;

  // Transaction modes
  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_BASE = 3'd1;
  localparam logic [2:0] MODE_AMP  = 3'd2;
  localparam logic [2:0] MODE_DEV  = 3'd3;
  localparam logic [2:0] MODE_ABS  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_INC,
    ST_OUT
  } state_t;

  localparam int SAMPLE_W   = 23;
  localparam int SAMPLE_MAX = 4194303;
  localparam int SAMPLE_MIN = -4194304;

  // Sine table: TABLE_SIZE steps over one period, plus a guard entry
  localparam int TABLE_BITS = 8;
  localparam int TABLE_SIZE = 256;
  localparam int HALF       = TABLE_SIZE / 2;
  localparam int QUARTER    = TABLE_SIZE / 4;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // round(32767 * sin(2*pi*i/TABLE_SIZE)) by quadrant symmetry and a
  // truncated Taylor series in Q2.30, rounded half up
  function automatic logic signed [15:0] sine_entry(int unsigned i);
    logic [63:0]        m;
    logic [63:0]        h;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic [63:0]        v;
    m = 64'(i % HALF);
    h = 64'(i / HALF);
    if (m > 64'(QUARTER)) begin
      m = 64'(HALF) - m;
    end
    x    = (64'd2 * PI_Q30 * m) / TABLE_SIZE;
    x2   = (x * x) >> 30;
    s    = $signed(x);
    term = ((x * x2) >> 30) / 6;
    s    = s - $signed(term);
    term = ((term * x2) >> 30) / 20;
    s    = s + $signed(term);
    term = ((term * x2) >> 30) / 42;
    s    = s - $signed(term);
    term = ((term * x2) >> 30) / 72;
    s    = s + $signed(term);
    term = ((term * x2) >> 30) / 110;
    s    = s - $signed(term);
    if (s < 0) begin
      s = 0;
    end
    v = ($unsigned(s) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (h[0]) begin
      v = -v;
    end
    return v[15:0];
  endfunction

endpackage

// ===== rtl/additive_sine_partial_synth_unit.sv =====
// ----------------------------------------------------------------------------
// additive_sine_partial_synth_unit: bank of sine partials summed per sample
// Tick: a top-down sweep over the partials yields one valid sample; one partial
// enters the shared phase/interpolate/multiply-accumulate pipe each cycle.
// Base increment: a sweep, one multiply per partial; deviation: one partial is
// recomputed; amplitude or absolute increment: a write. Not ready while busy.
// Reset clears control and valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module additive_sine_partial_synth_unit
  import asps_pkg::*;
#(
  parameter int PARTIALS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 mode,
  input  logic [5:0]                 partial_index,
  input  logic [31:0]                increment_value,
  input  logic signed [15:0]         amplitude_value,
  input  logic signed [15:0]         deviation_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample
);

  // Partial index, harmonic number, factor, product and accumulator widths
  localparam int IW = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;
  localparam int CW = $clog2(PARTIALS + 1);
  localparam int FW = CW + 16;
  localparam int PW = FW + 33;
  localparam int AW = CW + 20;

  state_t state, state_next;

  logic in_accept;
  logic idx_ok;
  logic [IW-1:0] wr_idx;
  logic tick_done, inc_done, load_out;

  // Sweep sequencer: walks partials from the top down
  logic          issue;
  logic          single;
  logic [IW-1:0] ptr;

  // Per-partial stores with valid bits (an unwritten entry reads as zero)
  logic [31:0]        phase_mem [PARTIALS];
  logic [31:0]        inc_mem   [PARTIALS];
  logic signed [15:0] amp_mem   [PARTIALS];
  logic signed [15:0] dev_mem   [PARTIALS];
  logic [PARTIALS-1:0] phase_vld, inc_vld, amp_vld, dev_vld;
  logic [31:0] base_inc;

  // Stage 1: registered read data
  logic               v1;
  logic [IW-1:0]      a1;
  logic [31:0]        ph_q, inc_q;
  logic signed [15:0] amp_q, dev_q;
  logic               ph_ok_q, inc_ok_q, amp_ok_q, dev_ok_q;

  logic [31:0]        ph_e, inc_e, phase_new;
  logic signed [15:0] amp_e, dev_e;
  logic               seen_pos, seen_now, act1, inc_run;
  logic [CW-1:0]      harm;
  logic signed [FW-1:0] factor;
  logic signed [PW-1:0] inc_prod;

  // Tick pipe registers
  logic act2, act3, act4, act5, act6;
  logic [31:0]        ph2;
  logic signed [15:0] amp2, amp3, amp4, amp5;
  logic [TABLE_BITS:0] ti_lo, ti_hi;
  logic signed [15:0] lo3, lo4;
  logic signed [16:0] diff3;
  logic signed [24:0] frac3;
  logic signed [41:0] mul1_4;
  logic signed [42:0] interp5;
  logic signed [58:0] prod6;
  logic signed [AW-1:0] acc;
  logic signed [SAMPLE_W-1:0] sample_sat;

  // Increment pipe registers
  logic                 iv2;
  logic [IW-1:0]        ia2;
  logic signed [PW-1:0] prod2;

  // Increment store write port
  logic          inc_we;
  logic [IW-1:0] inc_wa;
  logic [31:0]   inc_wd;

  // Sine ROM, built at elaboration
  logic signed [15:0] sine_rom [TABLE_SIZE + 1];

  for (genvar g = 0; g <= TABLE_SIZE; g++) begin : g_rom
    localparam logic signed [15:0] ENTRY = sine_entry(g);
    assign sine_rom[g] = ENTRY;
  end

  assign in_accept = in_valid && in_ready;
  assign idx_ok    = 32'(partial_index) < 32'(PARTIALS);
  assign wr_idx    = IW'(partial_index);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign tick_done = !issue && !v1 && !act2 && !act3 && !act4 && !act5 && !act6;
  assign inc_done  = !issue && !v1 && !iv2;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && mode == MODE_TICK) begin
          state_next = ST_TICK;
        end else if (in_accept && (mode == MODE_BASE || (mode == MODE_DEV && idx_ok))) begin
          state_next = ST_INC;
        end
      end
      ST_TICK: begin
        if (tick_done) begin
          state_next = ST_OUT;
        end
      end
      ST_INC: begin
        if (inc_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE) && !rst;
    load_out = (state == ST_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issue    <= 1'b0;
      single   <= 1'b0;
      ptr      <= '0;
      v1       <= 1'b0;
      a1       <= '0;
      act2     <= 1'b0;
      act3     <= 1'b0;
      act4     <= 1'b0;
      act5     <= 1'b0;
      act6     <= 1'b0;
      iv2      <= 1'b0;
      seen_pos <= 1'b0;
      acc      <= '0;
      base_inc <= '0;
    end else begin
      state <= state_next;
      v1    <= issue;
      a1    <= ptr;
      act2  <= act1;
      act3  <= act2;
      act4  <= act3;
      act5  <= act4;
      act6  <= act5;
      iv2   <= inc_run;
      if (in_accept) begin
        // Arm a top-down sweep; a deviation write recomputes one partial
        if (mode == MODE_TICK) begin
          issue    <= 1'b1;
          single   <= 1'b0;
          ptr      <= IW'(PARTIALS - 1);
          seen_pos <= 1'b0;
          acc      <= '0;
        end else if (mode == MODE_BASE) begin
          base_inc <= increment_value;
          issue    <= 1'b1;
          single   <= 1'b0;
          ptr      <= IW'(PARTIALS - 1);
        end else if (mode == MODE_DEV && idx_ok) begin
          issue  <= 1'b1;
          single <= 1'b1;
          ptr    <= wr_idx;
        end
      end else if (issue) begin
        if (single || ptr == '0) begin
          issue <= 1'b0;
        end else begin
          ptr <= ptr - 1'b1;
        end
      end
      if (v1 && state == ST_TICK) begin
        seen_pos <= seen_now;
      end
      if (act6) begin
        acc <= acc + AW'($signed(prod6[58:39]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stores: one write port and one registered read port each
  // --------------------------------------------------------------------------
  always_comb begin
    if (iv2) begin
      inc_we = 1'b1;
      inc_wa = ia2;
      inc_wd = prod2[43:12];
    end else begin
      inc_we = in_accept && mode == MODE_ABS && idx_ok;
      inc_wa = wr_idx;
      inc_wd = increment_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && mode == MODE_AMP && idx_ok) begin
      amp_mem[wr_idx] <= amplitude_value;
    end
    amp_q <= amp_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && mode == MODE_DEV && idx_ok) begin
      dev_mem[wr_idx] <= deviation_value;
    end
    dev_q <= dev_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (inc_we) begin
      inc_mem[inc_wa] <= inc_wd;
    end
    inc_q <= inc_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (act1) begin
      phase_mem[a1] <= phase_new;
    end
    ph_q <= phase_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_vld   <= '0;
      dev_vld   <= '0;
      inc_vld   <= '0;
      phase_vld <= '0;
    end else begin
      if (in_accept && mode == MODE_AMP && idx_ok) begin
        amp_vld[wr_idx] <= 1'b1;
      end
      if (in_accept && mode == MODE_DEV && idx_ok) begin
        dev_vld[wr_idx] <= 1'b1;
      end
      if (inc_we) begin
        inc_vld[inc_wa] <= 1'b1;
      end
      if (act1) begin
        phase_vld[a1] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    amp_ok_q <= amp_vld[ptr];
    dev_ok_q <= dev_vld[ptr];
    inc_ok_q <= inc_vld[ptr];
    ph_ok_q  <= phase_vld[ptr];
  end

  // --------------------------------------------------------------------------
  // Stage 1: limit tracking, phase advance, harmonic increment multiply
  // --------------------------------------------------------------------------
  always_comb begin
    amp_e = amp_ok_q ? amp_q : '0;
    dev_e = dev_ok_q ? dev_q : '0;
    ph_e  = ph_ok_q ? ph_q : '0;
    inc_e = inc_ok_q ? inc_q : '0;
    // Walking down, everything at or below the highest positive amplitude counts
    seen_now  = seen_pos || (v1 && amp_e > 16'sd0);
    act1      = v1 && (state == ST_TICK) && seen_now && (amp_e != 16'sd0);
    phase_new = ph_e + inc_e;
    inc_run   = v1 && (state == ST_INC);
    harm      = CW'(a1) + CW'(1);
    factor    = $signed(FW'({harm, 12'b0})) + FW'(dev_e);
    inc_prod  = $signed({1'b0, base_inc}) * factor;
  end

  // --------------------------------------------------------------------------
  // Stages 2 to 6: table lookup, interpolation, amplitude scaling
  // --------------------------------------------------------------------------
  always_comb begin
    ti_lo = {1'b0, ph2[31 -: TABLE_BITS]};
    ti_hi = ti_lo + 1'b1;
  end

  always_ff @(posedge clk) begin
    ph2     <= phase_new;
    amp2    <= amp_e;
    prod2   <= inc_prod;
    ia2     <= a1;
    lo3     <= sine_rom[ti_lo];
    diff3   <= {sine_rom[ti_hi][15], sine_rom[ti_hi]} - {sine_rom[ti_lo][15], sine_rom[ti_lo]};
    frac3   <= $signed({1'b0, ph2[23:0]});
    amp3    <= amp2;
    mul1_4  <= diff3 * frac3;
    lo4     <= lo3;
    amp4    <= amp3;
    interp5 <= $signed({{3{lo4[15]}}, lo4, 24'b0}) + 43'(mul1_4);
    amp5    <= amp4;
    prod6   <= amp5 * interp5;
  end

  // --------------------------------------------------------------------------
  // Output register: saturate and hold until taken
  // --------------------------------------------------------------------------
  always_comb begin
    if (acc > AW'(SAMPLE_MAX)) begin
      sample_sat = SAMPLE_W'(SAMPLE_MAX);
    end else if (acc < AW'(SAMPLE_MIN)) begin
      sample_sat = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sample_sat = acc[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample <= sample_sat;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !issue && !v1 && !act6 && !iv2)
    else $error("input ready while sweep pipe busy");

  a_tick_pipe: assert property (@(posedge clk) disable iff (rst)
    act2 |-> state == ST_TICK)
    else $error("tick pipe active outside tick");

  a_single_issue: assert property (@(posedge clk) disable iff (rst)
    (issue && single) |=> !issue)
    else $error("single-partial sweep issued twice");

  a_load_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && state == ST_IDLE)
    else $error("sample load lost");
`endif

endmodule
